[hw/rtl/ksr_pkg.sv]
// Package: shared types, codes and the CRC-16 byte step for the key slot replica router.
package ksr_pkg;

    localparam int RANGES_DEF       = 16;
    localparam int MAX_REPLICAS_DEF = 8;
    localparam int ENTRY_SPAN       = 16;
    localparam int SLOT_W           = 14;
    localparam int CRC_W            = 16;
    localparam int ENTRY_W          = 4;
    localparam int CNT_W            = 4;
    localparam int IDX_W            = 4;
    localparam int REPLICA_W        = 3;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_NOTICE = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [SLOT_W-1:0]  slot;
        logic               relaxed;
        logic               misconf;
        logic [ENTRY_W-1:0] entry;
        logic [SLOT_W-1:0]  low;
        logic [SLOT_W-1:0]  high;
        logic [CNT_W-1:0]   cnt;
        logic               found;
        logic [ENTRY_W-1:0] hit;
        logic [IDX_W-1:0]   idx;
    } beat_t;

    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0]       byte_in);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {byte_in, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (c[CRC_W-1])
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/ksr_front.sv]
// Front stage: key CRC accumulation and beat formation for the cell chain.
module ksr_front
    import ksr_pkg::*;
#(
    parameter int RANGES       = RANGES_DEF,
    parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [1:0]         kind,
    input  logic [7:0]         key_byte,
    input  logic               last_byte,
    input  logic               relaxed_read,
    input  logic               info_has_misconf,
    input  logic [ENTRY_W-1:0] entry_index,
    input  logic [SLOT_W-1:0]  range_low,
    input  logic [SLOT_W-1:0]  range_high,
    input  logic [CNT_W-1:0]   replica_count,
    output beat_t              beat
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] crc_step;
    beat_t            beat_reg;
    beat_t            beat_next;
    logic [CNT_W-1:0] cnt_min;
    logic [CNT_W:0]   cnt_sat;
    kind_t            kind_in;

    assign kind_in = kind_t'(kind);

    always_comb
    begin
        crc_step = crc_feed(crc_reg, key_byte);
        crc_next = crc_reg;
        cnt_min  = (replica_count == '0) ? CNT_W'(1) : replica_count;
        if (int'(cnt_min) > MAX_REPLICAS)
        begin
            cnt_sat = (CNT_W+1)'(MAX_REPLICAS);
        end
        else
        begin
            cnt_sat = {1'b0, cnt_min};
        end

        beat_next.valid   = 1'b0;
        beat_next.kind    = kind_in;
        beat_next.slot    = crc_step[SLOT_W-1:0];
        beat_next.relaxed = relaxed_read;
        beat_next.misconf = info_has_misconf;
        beat_next.entry   = entry_index;
        beat_next.low     = range_low;
        beat_next.high    = range_high;
        beat_next.cnt     = cnt_sat[CNT_W-1:0];
        beat_next.found   = 1'b0;
        beat_next.hit     = '0;
        beat_next.idx     = '0;

        if (accept)
        begin
            unique case (kind_in)
                KIND_WRITE:
                begin
                    beat_next.valid = (int'(entry_index) < RANGES);
                end
                KIND_LOOKUP, KIND_NOTICE:
                begin
                    beat_next.valid = last_byte;
                    crc_next        = last_byte ? '0 : crc_step;
                end
                default:
                begin
                    beat_next.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= '0;
            beat_reg <= '0;
        end
        else
        begin
            crc_reg  <= crc_next;
            beat_reg <= beat_next;
        end
    end

    assign beat = beat_reg;

    a_crc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte && (kind_in == KIND_LOOKUP || kind_in == KIND_NOTICE)
        |=> crc_reg == '0)
        else $error("key CRC not cleared after last byte");

endmodule

[hw/rtl/ksr_cell.sv]
// Chain cell: one range entry with its rotation and failed mark; matches passing beats.
module ksr_cell
    import ksr_pkg::*;
#(
    parameter int MAX_REPLICAS = MAX_REPLICAS_DEF,
    parameter int IDX          = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  beat_t beat_in,
    output beat_t beat_out
);

    localparam int RW = $clog2(MAX_REPLICAS);
    localparam int CW = $clog2(MAX_REPLICAS + 1);

    logic              valid_reg;
    logic              valid_next;
    logic              failed_reg;
    logic              failed_next;
    logic [RW-1:0]     rot_reg;
    logic [RW-1:0]     rot_next;
    logic [SLOT_W-1:0] low_reg;
    logic [SLOT_W-1:0] high_reg;
    logic [CW-1:0]     cnt_reg;
    logic [RW:0]       rot_inc;
    logic [RW-1:0]     pick;
    logic              wr_here;
    logic              hit_here;
    beat_t             out_reg;
    beat_t             out_next;

    always_comb
    begin
        wr_here  = beat_in.valid && (beat_in.kind == KIND_WRITE) &&
                   (IDX < ENTRY_SPAN) && (beat_in.entry == ENTRY_W'(IDX));
        hit_here = beat_in.valid && !beat_in.found && valid_reg &&
                   (beat_in.kind == KIND_LOOKUP || beat_in.kind == KIND_NOTICE) &&
                   (low_reg <= beat_in.slot) && (beat_in.slot <= high_reg);
        rot_inc     = {1'b0, rot_reg} + 1'b1;
        out_next    = beat_in;
        valid_next  = valid_reg;
        failed_next = failed_reg;
        rot_next    = rot_reg;
        pick        = '0;

        if (wr_here)
        begin
            valid_next  = 1'b1;
            failed_next = 1'b0;
            rot_next    = '0;
        end
        else if (hit_here)
        begin
            out_next.found = 1'b1;
            out_next.hit   = ENTRY_W'(IDX);
            if (beat_in.kind == KIND_LOOKUP)
            begin
                if (beat_in.relaxed)
                begin
                    pick     = rot_reg;
                    rot_next = (rot_inc >= (RW+1)'(cnt_reg)) ? '0 : rot_inc[RW-1:0];
                end
                if (pick == '0 && failed_reg && cnt_reg > CW'(1))
                begin
                    pick = RW'(1);
                end
            end
            else if (!beat_in.misconf)
            begin
                failed_next = 1'b1;
            end
            out_next.idx = IDX_W'(pick);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            failed_reg <= 1'b0;
            rot_reg    <= '0;
            out_reg    <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            failed_reg <= failed_next;
            rot_reg    <= rot_next;
            out_reg    <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            low_reg  <= beat_in.low;
            high_reg <= beat_in.high;
            cnt_reg  <= CW'(beat_in.cnt);
        end
    end

    assign beat_out = out_reg;

    a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ({1'b0, rot_reg} < (RW+1)'(cnt_reg)))
        else $error("rotation beyond replica count");

    a_first_hit: assert property (@(posedge clk) disable iff (!rst_n)
        beat_in.valid && beat_in.found
        |=> beat_out.found && beat_out.hit == $past(beat_in.hit))
        else $error("earlier match overwritten downstream");

endmodule

[hw/rtl/key_slot_replica_router_top.sv]
// Top level: key slot replica router, CRC front stage followed by a chain of range cells.
// The last key byte's beat passes the front register, then each cell register, to done.
// Throughput: one beat per cycle; busy stays low, each cell passes the beat on every cycle.
// The front register and the RANGES chain cells, one register stage each, set the latency.
// Reset clears the key CRC, entry valid bits, rotations, failed marks and beats in flight.
// Results are strobed by done for one cycle; the receiver cannot stall.
module key_slot_replica_router_top
    import ksr_pkg::*;
#(
    parameter int RANGES       = RANGES_DEF,
    parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           kind,
    input  logic [7:0]           key_byte,
    input  logic                 last_byte,
    input  logic                 relaxed_read,
    input  logic                 info_has_misconf,
    input  logic [ENTRY_W-1:0]   entry_index,
    input  logic [SLOT_W-1:0]    range_low,
    input  logic [SLOT_W-1:0]    range_high,
    input  logic [CNT_W-1:0]     replica_count,
    output logic                 done,
    output logic                 found,
    output logic [ENTRY_W-1:0]   range_hit,
    output logic [REPLICA_W-1:0] replica_index,
    output logic [SLOT_W-1:0]    slot
);

    beat_t chain [RANGES+1];
    beat_t tail;

    assign busy = 1'b0;

    ksr_front #(
        .RANGES       (RANGES),
        .MAX_REPLICAS (MAX_REPLICAS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (start && !busy),
        .kind             (kind),
        .key_byte         (key_byte),
        .last_byte        (last_byte),
        .relaxed_read     (relaxed_read),
        .info_has_misconf (info_has_misconf),
        .entry_index      (entry_index),
        .range_low        (range_low),
        .range_high       (range_high),
        .replica_count    (replica_count),
        .beat             (chain[0])
    );

    for (genvar i = 0; i < RANGES; i++)
    begin : g_cell
        ksr_cell #(
            .MAX_REPLICAS (MAX_REPLICAS),
            .IDX          (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    assign tail          = chain[RANGES];
    assign done          = tail.valid && (tail.kind != KIND_WRITE);
    assign found         = tail.found;
    assign range_hit     = tail.hit;
    assign replica_index = tail.idx[REPLICA_W-1:0];
    assign slot          = tail.slot;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !found |-> range_hit == '0 && replica_index == '0)
        else $error("miss result carries nonzero hit or replica");

    a_notice_primary: assert property (@(posedge clk) disable iff (!rst_n)
        done && tail.kind == KIND_NOTICE |-> replica_index == '0)
        else $error("failure notice returned nonzero replica");

endmodule
